FILE: rtl/core/brsg_pkg.sv
// Package for the bicubic RGB sampler: sizes, state machine type and codes.
// Used by the top level under rtl/core; depends on nothing.
`timescale 1ns / 1ps
package brsg_pkg;
	localparam int IMG_MAX    = 256;
	localparam int DIM_W      = 9;
	localparam int COORD_W    = 18;
	localparam int FRAC_BITS  = 8;
	localparam int PIX_W      = 24;
	localparam int BANKS      = 4;
	localparam int BANK_DEPTH = IMG_MAX * IMG_MAX / BANKS;
	localparam int WGT_W      = 12;
	localparam int HS_W       = 24;
	localparam int ACC_W      = 40;
	localparam int OUT_W      = 18;

	localparam logic       ACT_WRITE  = 1'b0;
	localparam logic       ACT_SAMPLE = 1'b1;
	localparam logic       REG_WIDTH  = 1'b0;
	localparam logic       REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CUBE,
		ST_WEIGHT,
		ST_ROWS,
		ST_DRAIN
	} state_t;
endpackage

FILE: rtl/core/brsg_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module brsg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/bicubic_rgb_sampler_with_gradient_unit.sv
// Top level of the bicubic RGB sampler: frame store in four column banks,
// Catmull-Rom weights, row-serial filtering. Depends on brsg_pkg and brsg_ram.
// A pixel write leaves busy low and produces no result.
// A sample raises done when it finishes and accepts the next one with done, so a new sample
// waits until the last is through (out-of-range samples finish early); the result cannot be stalled.
// Reset sets both size registers to 256; the frame store is undefined until written.
`timescale 1ns / 1ps
module bicubic_rgb_sampler_with_gradient_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic [7:0]                         write_col,
	input  logic [7:0]                         write_row,
	input  logic [7:0]                         red_in,
	input  logic [7:0]                         green_in,
	input  logic [7:0]                         blue_in,
	input  logic signed [brsg_pkg::COORD_W-1:0] sample_x,
	input  logic signed [brsg_pkg::COORD_W-1:0] sample_y,
	output logic                               done,
	output logic                               out_of_range,
	output logic signed [brsg_pkg::OUT_W-1:0]  color_red,
	output logic signed [brsg_pkg::OUT_W-1:0]  color_green,
	output logic signed [brsg_pkg::OUT_W-1:0]  color_blue,
	output logic signed [brsg_pkg::OUT_W-1:0]  grad_red_x,
	output logic signed [brsg_pkg::OUT_W-1:0]  grad_red_y,
	output logic signed [brsg_pkg::OUT_W-1:0]  grad_green_x,
	output logic signed [brsg_pkg::OUT_W-1:0]  grad_green_y,
	output logic signed [brsg_pkg::OUT_W-1:0]  grad_blue_x,
	output logic signed [brsg_pkg::OUT_W-1:0]  grad_blue_y
);
	localparam int AW = $clog2(brsg_pkg::BANK_DEPTH);
	localparam int BANKS_M1 = brsg_pkg::BANKS - 1;

	brsg_pkg::state_t state_q, state_d;

	logic [brsg_pkg::DIM_W-1:0] width_q, height_q, w_eff, h_eff;
	logic signed [brsg_pkg::COORD_W-1:0] x_q, y_q;
	logic [7:0]  ux_q, uy_q;
	logic [15:0] ux2_q, uy2_q;
	logic [23:0] ux3_q, uy3_q;
	logic [8:0]  iy_q;
	logic [7:0]  lo_q;
	logic [1:0]  offs_q [4];
	logic signed [brsg_pkg::WGT_W-1:0] wx_q [4], dx_q [4], wy_q [4], dy_q [4];
	logic [1:0]  r_q, r_s1, r_s2;
	logic        rd_v_s1, v_s2, fin_q;
	logic signed [brsg_pkg::HS_W-1:0]  hs_s2 [3], hd_s2 [3];
	logic signed [brsg_pkg::ACC_W-1:0] col_q [3], gx_q [3], gy_q [3];
	logic        done_q, oor_q;
	logic signed [brsg_pkg::OUT_W-1:0] res_q [9];

	logic                   accept, oor;
	logic signed [9:0]      ix, iy;
	logic signed [10:0]     lo_c, sx_c [4], sy_c;
	logic [7:0]             lo_n, sy;
	logic [1:0]             offs_n [4];
	logic                   wr_ok;
	logic [BANKS_M1:0]      wen;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr [4];
	logic [brsg_pkg::PIX_W-1:0] rdata [4];
	logic [brsg_pkg::PIX_W-1:0] tap [4];
	logic signed [brsg_pkg::HS_W-1:0] hs_n [3], hd_n [3];
	logic signed [20:0]     pr_w, pr_d;
	logic [7:0]             bcol;

	function automatic logic signed [brsg_pkg::WGT_W-1:0] cubic_w(
		input logic [7:0] u, input logic [15:0] u2, input logic [23:0] u3,
		input logic [1:0] k);
		logic signed [28:0] p1, p2, p3, v, r;
		p1 = $signed({21'd0, u});
		p2 = $signed({13'd0, u2});
		p3 = $signed({5'd0, u3});
		unique case (k)
			2'd0: v = -p3 + (p2 <<< 9) - (p1 <<< 16);
			2'd1: v = 29'sd3 * p3 - 29'sd5 * (p2 <<< 8) + (29'sd1 <<< 25);
			2'd2: v = -(29'sd3 * p3) + (p2 <<< 10) + (p1 <<< 16);
			default: v = p3 - (p2 <<< 8);
		endcase
		r = (v + (29'sd1 <<< 16)) >>> 17;
		return r[brsg_pkg::WGT_W-1:0];
	endfunction

	function automatic logic signed [brsg_pkg::WGT_W-1:0] deriv_w(
		input logic [7:0] u, input logic [15:0] u2, input logic [1:0] k);
		logic signed [21:0] p1, p2, v, r;
		p1 = $signed({14'd0, u});
		p2 = $signed({6'd0, u2});
		unique case (k)
			2'd0: v = -(22'sd3 * p2) + (p1 <<< 10) - (22'sd1 <<< 16);
			2'd1: v = 22'sd9 * p2 - 22'sd10 * (p1 <<< 8);
			2'd2: v = -(22'sd9 * p2) + 22'sd8 * (p1 <<< 8) + (22'sd1 <<< 16);
			default: v = 22'sd3 * p2 - 22'sd2 * (p1 <<< 8);
		endcase
		r = (v + 22'sd256) >>> 9;
		return r[brsg_pkg::WGT_W-1:0];
	endfunction

	function automatic logic signed [brsg_pkg::OUT_W-1:0] rnd_sat(
		input logic signed [brsg_pkg::ACC_W-1:0] a);
		logic signed [brsg_pkg::ACC_W-1:0] t;
		t = (a + 40'sd128) >>> 8;
		if (t > 40'sd131071) begin
			return 18'sh1FFFF;
		end else if (t < -40'sd131072) begin
			return -18'sh20000;
		end
		return t[brsg_pkg::OUT_W-1:0];
	endfunction

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == brsg_pkg::REG_HEIGHT) ? {23'd0, height_q} : {23'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == brsg_pkg::REG_HEIGHT) begin
				height_q <= pwdata[8:0];
			end else begin
				width_q <= pwdata[8:0];
			end
		end
	end

	always_comb begin
		if (width_q < 9'd4) begin
			w_eff = 9'd4;
		end else if (width_q > 9'(brsg_pkg::IMG_MAX)) begin
			w_eff = 9'(brsg_pkg::IMG_MAX);
		end else begin
			w_eff = width_q;
		end
		if (height_q < 9'd4) begin
			h_eff = 9'd4;
		end else if (height_q > 9'(brsg_pkg::IMG_MAX)) begin
			h_eff = 9'(brsg_pkg::IMG_MAX);
		end else begin
			h_eff = height_q;
		end
	end

	// Control.
	assign busy   = (state_q != brsg_pkg::ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			brsg_pkg::ST_IDLE: begin
				if (accept && action == brsg_pkg::ACT_SAMPLE) begin
					state_d = brsg_pkg::ST_PREP;
				end
			end
			brsg_pkg::ST_PREP:   state_d = oor ? brsg_pkg::ST_IDLE : brsg_pkg::ST_CUBE;
			brsg_pkg::ST_CUBE:   state_d = brsg_pkg::ST_WEIGHT;
			brsg_pkg::ST_WEIGHT: state_d = brsg_pkg::ST_ROWS;
			brsg_pkg::ST_ROWS: begin
				if (r_q == 2'd3) begin
					state_d = brsg_pkg::ST_DRAIN;
				end
			end
			brsg_pkg::ST_DRAIN: begin
				if (fin_q) begin
					state_d = brsg_pkg::ST_IDLE;
				end
			end
			default: state_d = brsg_pkg::ST_IDLE;
		endcase
	end

	// Coordinate preparation.
	always_comb begin
		ix   = x_q[17:8];
		iy   = y_q[17:8];
		oor  = ix[9] || iy[9] || (ix[8:0] > w_eff) || (iy[8:0] > h_eff);
		lo_c = 11'(ix) - 11'sd1;
		if (lo_c < 11'sd0) begin
			lo_c = 11'sd0;
		end else if (lo_c > $signed({2'b0, w_eff}) - 11'sd4) begin
			lo_c = $signed({2'b0, w_eff}) - 11'sd4;
		end
		lo_n = lo_c[7:0];
		for (int c = 0; c < 4; c++) begin
			sx_c[c] = 11'(ix) - 11'sd1 + 11'(c);
			if (sx_c[c] < 11'sd0) begin
				sx_c[c] = 11'sd0;
			end else if (sx_c[c] > $signed({2'b0, w_eff}) - 11'sd1) begin
				sx_c[c] = $signed({2'b0, w_eff}) - 11'sd1;
			end
			offs_n[c] = 2'(sx_c[c] - lo_c);
		end
		sy_c = $signed({2'b0, iy_q}) - 11'sd1 + $signed({9'd0, r_q});
		if (sy_c < 11'sd0) begin
			sy_c = 11'sd0;
		end else if (sy_c > $signed({2'b0, h_eff}) - 11'sd1) begin
			sy_c = $signed({2'b0, h_eff}) - 11'sd1;
		end
		sy = sy_c[7:0];
	end

	// Frame store: bank b holds the columns whose two low bits equal b.
	assign wr_ok = accept && (action == brsg_pkg::ACT_WRITE)
		&& ({1'b0, write_col} < w_eff) && ({1'b0, write_row} < h_eff);
	assign waddr = {write_row, write_col[7:2]};

	always_comb begin
		for (int b = 0; b < brsg_pkg::BANKS; b++) begin
			wen[b]   = wr_ok && (write_col[1:0] == 2'(b));
			bcol     = lo_q + 8'(2'(2'(b) - lo_q[1:0]));
			raddr[b] = {sy, bcol[7:2]};
		end
	end

	for (genvar g = 0; g < brsg_pkg::BANKS; g++) begin : g_bank
		brsg_ram #(
			.WIDTH(brsg_pkg::PIX_W),
			.DEPTH(brsg_pkg::BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (wen[g]),
			.waddr(waddr),
			.wdata({blue_in, green_in, red_in}),
			.raddr(raddr[g]),
			.rdata(rdata[g])
		);
	end

	// Horizontal filter of one row.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			tap[c] = rdata[2'(lo_q[1:0] + offs_q[c])];
		end
		for (int k = 0; k < 3; k++) begin
			hs_n[k] = '0;
			hd_n[k] = '0;
			for (int c = 0; c < 4; c++) begin
				pr_w = $signed({1'b0, tap[c][8*k +: 8]}) * wx_q[c];
				pr_d = $signed({1'b0, tap[c][8*k +: 8]}) * dx_q[c];
				hs_n[k] = hs_n[k] + brsg_pkg::HS_W'(pr_w);
				hd_n[k] = hd_n[k] + brsg_pkg::HS_W'(pr_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			rd_v_s1 <= (state_q == brsg_pkg::ST_ROWS);
			v_s2    <= rd_v_s1;
			if (state_q == brsg_pkg::ST_ROWS) begin
				r_q <= r_q + 2'd1;
			end else begin
				r_q <= '0;
			end
			if (v_s2 && r_s2 == 2'd3) begin
				fin_q <= 1'b1;
			end else if (state_q == brsg_pkg::ST_DRAIN) begin
				fin_q <= 1'b0;
			end
			if ((state_q == brsg_pkg::ST_PREP && oor)
				|| (state_q == brsg_pkg::ST_DRAIN && fin_q)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_x;
			y_q <= sample_y;
		end
		if (state_q == brsg_pkg::ST_PREP) begin
			ux_q  <= x_q[7:0];
			uy_q  <= y_q[7:0];
			ux2_q <= x_q[7:0] * x_q[7:0];
			uy2_q <= y_q[7:0] * y_q[7:0];
			iy_q  <= iy[8:0];
			lo_q  <= lo_n;
			offs_q <= offs_n;
			if (oor) begin
				oor_q <= 1'b1;
				for (int i = 0; i < 9; i++) begin
					res_q[i] <= '0;
				end
			end
		end
		if (state_q == brsg_pkg::ST_CUBE) begin
			ux3_q <= ux2_q * ux_q;
			uy3_q <= uy2_q * uy_q;
		end
		if (state_q == brsg_pkg::ST_WEIGHT) begin
			for (int c = 0; c < 4; c++) begin
				wx_q[c] <= cubic_w(ux_q, ux2_q, ux3_q, 2'(c));
				wy_q[c] <= cubic_w(uy_q, uy2_q, uy3_q, 2'(c));
				dx_q[c] <= deriv_w(ux_q, ux2_q, 2'(c));
				dy_q[c] <= deriv_w(uy_q, uy2_q, 2'(c));
			end
		end
		r_s1 <= r_q;
		if (rd_v_s1) begin
			r_s2  <= r_s1;
			hs_s2 <= hs_n;
			hd_s2 <= hd_n;
		end
		if (v_s2) begin
			for (int k = 0; k < 3; k++) begin
				if (r_s2 == 2'd0) begin
					col_q[k] <= brsg_pkg::ACC_W'(hs_s2[k] * wy_q[r_s2]);
					gx_q[k]  <= brsg_pkg::ACC_W'(hd_s2[k] * wy_q[r_s2]);
					gy_q[k]  <= brsg_pkg::ACC_W'(hs_s2[k] * dy_q[r_s2]);
				end else begin
					col_q[k] <= col_q[k] + brsg_pkg::ACC_W'(hs_s2[k] * wy_q[r_s2]);
					gx_q[k]  <= gx_q[k] + brsg_pkg::ACC_W'(hd_s2[k] * wy_q[r_s2]);
					gy_q[k]  <= gy_q[k] + brsg_pkg::ACC_W'(hs_s2[k] * dy_q[r_s2]);
				end
			end
		end
		if (state_q == brsg_pkg::ST_DRAIN && fin_q) begin
			oor_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				res_q[k]         <= rnd_sat(col_q[k]);
				res_q[3 + 2 * k] <= rnd_sat(gx_q[k]);
				res_q[4 + 2 * k] <= rnd_sat(gy_q[k]);
			end
		end
	end

	assign done         = done_q;
	assign out_of_range = oor_q;
	assign color_red    = res_q[0];
	assign color_green  = res_q[1];
	assign color_blue   = res_q[2];
	assign grad_red_x   = res_q[3];
	assign grad_red_y   = res_q[4];
	assign grad_green_x = res_q[5];
	assign grad_green_y = res_q[6];
	assign grad_blue_x  = res_q[7];
	assign grad_blue_y  = res_q[8];
endmodule
